// ===== rtl/grec_pkg.sv =====
package grec_pkg;

   // Configuration registers are 7 bits wide, so no grid can exceed 127 tiles
   // on a side and tile coordinates always fit in the same width.
   localparam int CFG_W     = 7;
   localparam int CFG_MAX   = 127;
   localparam int POS_W     = 7;
   localparam int PIX_W     = 11;
   localparam int CSR_IDX_W = 2;

   // Entries in the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 7'd64;
   localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 7'd64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 2'd0,
      CSR_GRID_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic tile_solid;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] rect_left;
      logic [PIX_W-1:0] rect_top;
      logic [PIX_W-1:0] rect_width;
      logic [PIX_W-1:0] rect_height;
      logic             is_column;
      logic             last_of_item;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     data;
   } csr_type;

   // One classified tile as it travels from the front to the back part.
   typedef struct packed {
      logic             tile_solid;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             last_col;
      logic             last_row;
   } item_type;

endpackage

// ===== rtl/grec_chan_if.sv =====
interface grec_chan_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/grec_ram.sv =====
module grec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Read returns the old contents when the same address is written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/grec_front.sv =====
module grec_front
   import grec_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   grec_chan_if.sink   req_chan,
   grec_chan_if.sink   csr_chan,
   grec_chan_if.source item_chan
);

   localparam logic [CFG_W-1:0] WIDTH_LIM =
      (MAX_WIDTH < CFG_MAX) ? CFG_W'(MAX_WIDTH) : CFG_W'(CFG_MAX);
   localparam logic [CFG_W-1:0] HEIGHT_LIM =
      (MAX_HEIGHT < CFG_MAX) ? CFG_W'(MAX_HEIGHT) : CFG_W'(CFG_MAX);

   logic [CFG_W-1:0] grid_width_ff;
   logic [CFG_W-1:0] grid_width_in;
   logic [CFG_W-1:0] grid_height_ff;
   logic [CFG_W-1:0] grid_height_in;
   logic [CFG_W-1:0] width_eff;
   logic [CFG_W-1:0] height_eff;
   logic [POS_W-1:0] col_ff;
   logic [POS_W-1:0] col_in;
   logic [POS_W-1:0] row_ff;
   logic [POS_W-1:0] row_in;
   logic             last_col;
   logic             last_row;
   logic             accept;
   item_type         item;

   assign csr_chan.ready = 1'b1;

   // Out-of-range register values act as the nearest legal size.
   always_comb begin
      width_eff = grid_width_ff;
      if (grid_width_ff == '0) begin
         width_eff = CFG_W'(1);
      end else if (grid_width_ff > WIDTH_LIM) begin
         width_eff = WIDTH_LIM;
      end
      height_eff = grid_height_ff;
      if (grid_height_ff == '0) begin
         height_eff = CFG_W'(1);
      end else if (grid_height_ff > HEIGHT_LIM) begin
         height_eff = HEIGHT_LIM;
      end
   end

   assign last_col = ((POS_W + 1)'(col_ff) + (POS_W + 1)'(1)) >= (POS_W + 1)'(width_eff);
   assign last_row = ((POS_W + 1)'(row_ff) + (POS_W + 1)'(1)) >= (POS_W + 1)'(height_eff);

   always_comb begin
      item.tile_solid = req_chan.payload.tile_solid;
      item.col        = col_ff;
      item.row        = row_ff;
      item.last_col   = last_col;
      item.last_row   = last_row;
   end

   assign item_chan.valid   = req_chan.valid;
   assign item_chan.payload = item;
   assign req_chan.ready    = item_chan.ready;
   assign accept            = req_chan.valid && item_chan.ready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + POS_W'(1);
         end else begin
            col_in = col_ff + POS_W'(1);
         end
      end
   end

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.payload.index)
            CSR_GRID_WIDTH: begin
               grid_width_in = csr_chan.payload.data;
            end
            CSR_GRID_HEIGHT: begin
               grid_height_in = csr_chan.payload.data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         col_ff         <= '0;
         row_ff         <= '0;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
      end
   end

endmodule

// ===== rtl/grec_queue.sv =====
module grec_queue
   import grec_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   grec_chan_if.sink   push_chan,
   grec_chan_if.source pop_chan
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_chan.ready  = (count_ff != CNT_W'(DEPTH));
   assign pop_chan.valid   = (count_ff != '0);
   assign pop_chan.payload = slot_ff[rd_ptr_ff];

   assign push = push_chan.valid && push_chan.ready;
   assign pop  = pop_chan.valid && pop_chan.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_chan.payload;
      end
   end

   // The fill count never runs past the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count exceeds its depth");

endmodule

// ===== rtl/grec_back.sv =====
module grec_back
   import grec_pkg::*;
#(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int TILE_PIXELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   grec_chan_if.sink   item_chan,
   grec_chan_if.source rsp_chan
);

   localparam int STORE_DEPTH = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int ROW_LIM     = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
   localparam int START_W     = (ROW_LIM > 1) ? $clog2(ROW_LIM) : 1;
   localparam int WORD_W      = START_W + 2;
   localparam int MUL_W       = POS_W + $clog2(TILE_PIXELS + 1);
   localparam int PROD_W      = (MUL_W > PIX_W) ? MUL_W : PIX_W;
   localparam logic [PIX_W-1:0] PIX_ONE = PIX_W'(TILE_PIXELS);

   typedef struct packed {
      logic               prev;
      logic               older;
      logic [START_W-1:0] col_start;
   } word_type;

   typedef struct packed {
      logic [POS_W-1:0] left;
      logic [POS_W-1:0] top;
      logic [POS_W-1:0] wid;
      logic [POS_W-1:0] hgt;
      logic             is_column;
   } rect_type;

   function automatic logic [PIX_W-1:0] to_pix(input logic [POS_W-1:0] tiles);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(tiles) * PROD_W'(TILE_PIXELS);
      return prod[PIX_W-1:0];
   endfunction

   logic                   exec_valid_ff;
   logic                   exec_valid_in;
   item_type               exec_ff;
   item_type               exec_in;
   logic [2:0]             done_ff;
   logic [2:0]             done_in;
   logic [POS_W-1:0]       dstart_ff;
   logic [POS_W-1:0]       dstart_in;
   logic [POS_W-1:0]       cstart_ff;
   logic [POS_W-1:0]       cstart_in;
   logic [STORE_DEPTH-1:0] vld_ff;
   logic [STORE_DEPTH-1:0] vld_in;
   logic                   fwd_a_ff;
   logic                   fwd_a_in;
   logic                   fwd_b_ff;
   logic                   fwd_b_in;
   logic                   vld_a_ff;
   logic                   vld_a_in;
   logic                   vld_b_ff;
   logic                   vld_b_in;
   word_type               fwd_word_ff;
   word_type               fwd_word_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic [WORD_W-1:0]      rd_data_a;
   logic [WORD_W-1:0]      rd_data_b;
   word_type               word_a;
   word_type               word_b;
   word_type               wr_word;
   logic [ADDR_W-1:0]      rd_addr_a;
   logic [ADDR_W-1:0]      rd_addr_b;
   logic [ADDR_W-1:0]      wr_addr;
   item_type               head;
   logic                   pop;
   logic                   pop_take;
   logic                   finish;
   logic                   emit;
   logic                   out_free;
   logic                   any_pend;
   logic                   last_pend;
   logic                   p;
   logic                   o;
   logic                   pn;
   logic                   t;
   logic [POS_W-1:0]       x;
   logic [POS_W-1:0]       y;
   logic [POS_W-1:0]       dst;
   logic [POS_W-1:0]       cst;
   logic [POS_W-1:0]       col_start;
   logic [POS_W-1:0]       col_new;
   logic [POS_W-1:0]       s_a;
   logic [POS_W-1:0]       len_a;
   logic [POS_W-1:0]       s_b;
   logic [POS_W-1:0]       len_b;
   logic [POS_W-1:0]       s_c;
   logic [POS_W-1:0]       len_c;
   logic [2:0]             rect_en;
   logic [2:0]             pend;
   logic [2:0]             sel_mask;
   rect_type               rect_above;
   rect_type               rect_last;
   rect_type               rect_col;
   rect_type               sel_rect;

   // Line stores: previous row flag, the row before that, and the open
   // vertical run start, one word per tile column.
   grec_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock     (clock),
      .wr_en     (finish),
      .wr_addr   (wr_addr),
      .wr_data   (wr_word),
      .rd_en     (pop_take),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign head      = item_chan.payload;
   assign rd_addr_a = head.col[ADDR_W-1:0];
   assign rd_addr_b = head.last_col ? rd_addr_a : rd_addr_a + ADDR_W'(1);
   assign wr_addr   = exec_ff.col[ADDR_W-1:0];

   // Evaluate the tile in the execute register against its neighbors.
   always_comb begin
      word_a    = fwd_a_ff ? fwd_word_ff : word_type'(rd_data_a);
      word_b    = fwd_b_ff ? fwd_word_ff : word_type'(rd_data_b);
      p         = (fwd_a_ff | vld_a_ff) & word_a.prev;
      o         = (fwd_a_ff | vld_a_ff) & word_a.older;
      pn        = (fwd_b_ff | vld_b_ff) & word_b.prev;
      col_start = POS_W'(word_a.col_start);
      t         = exec_ff.tile_solid;
      x         = exec_ff.col;
      y         = exec_ff.row;
      dst       = (x == '0) ? '0 : dstart_ff;
      cst       = (x == '0) ? '0 : cstart_ff;

      s_a        = (dst > x) ? x : dst;
      len_a      = x - s_a + POS_W'(1);
      rect_en[0] = (y != '0) && p && (exec_ff.last_col || !pn) &&
                   ((len_a >= POS_W'(2)) || (y == POS_W'(1)) || (!o && !t));
      rect_above = '{left: s_a, top: y - POS_W'(1), wid: len_a, hgt: POS_W'(1),
                     is_column: 1'b0};

      if (!t) begin
         s_b        = cst;
         len_b      = x - cst;
         rect_en[1] = exec_ff.last_row && (cst < x);
      end else begin
         s_b        = (cst > x) ? x : cst;
         len_b      = x - s_b + POS_W'(1);
         rect_en[1] = exec_ff.last_row && exec_ff.last_col;
      end
      rect_last = '{left: s_b, top: y, wid: len_b, hgt: POS_W'(1), is_column: 1'b0};

      col_new = (t && ((y == '0) || !p)) ? y : col_start;
      if (!t) begin
         s_c        = (col_start > y - POS_W'(1)) ? y - POS_W'(1) : col_start;
         len_c      = y - s_c;
         rect_en[2] = (y != '0) && p && (len_c >= POS_W'(2));
      end else begin
         s_c        = (col_new > y) ? y : col_new;
         len_c      = y - s_c + POS_W'(1);
         rect_en[2] = exec_ff.last_row && (len_c >= POS_W'(2));
      end
      rect_col = '{left: x, top: s_c, wid: POS_W'(1), hgt: len_c, is_column: 1'b1};

      wr_word = '{prev: t, older: p, col_start: col_new[START_W-1:0]};
   end

   // Rectangles leave in a fixed order, one per cycle while the output register is free.
   always_comb begin
      pend     = rect_en & ~done_ff;
      any_pend = |pend;
      if (pend[0]) begin
         sel_mask = 3'b001;
         sel_rect = rect_above;
      end else if (pend[1]) begin
         sel_mask = 3'b010;
         sel_rect = rect_last;
      end else begin
         sel_mask = 3'b100;
         sel_rect = rect_col;
      end
      last_pend = ((pend & ~sel_mask) == '0);
   end

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = exec_valid_ff && any_pend && out_free;
   assign finish   = exec_valid_ff && (!any_pend || (emit && last_pend));
   assign pop      = !exec_valid_ff || finish;
   assign pop_take = pop && item_chan.valid;

   assign item_chan.ready  = pop;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   always_comb begin
      exec_valid_in = pop ? item_chan.valid : exec_valid_ff;
      exec_in       = pop_take ? head : exec_ff;
      done_in       = pop ? '0 : (emit ? (done_ff | sel_mask) : done_ff);

      dstart_in = dstart_ff;
      cstart_in = cstart_ff;
      vld_in    = vld_ff;
      if (finish) begin
         dstart_in       = ((y != '0) && !p) ? x + POS_W'(1) : dst;
         cstart_in       = !t ? x + POS_W'(1) : cst;
         vld_in[wr_addr] = 1'b1;
      end

      // A word written in the same cycle as the read is forwarded.
      fwd_a_in    = fwd_a_ff;
      fwd_b_in    = fwd_b_ff;
      vld_a_in    = vld_a_ff;
      vld_b_in    = vld_b_ff;
      fwd_word_in = fwd_word_ff;
      if (pop_take) begin
         fwd_a_in    = finish && (wr_addr == rd_addr_a);
         fwd_b_in    = finish && (wr_addr == rd_addr_b);
         vld_a_in    = vld_ff[rd_addr_a];
         vld_b_in    = vld_ff[rd_addr_b];
         fwd_word_in = wr_word;
      end

      rsp_valid_in = out_free ? emit : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_in.rect_left    = to_pix(sel_rect.left);
         rsp_in.rect_top     = to_pix(sel_rect.top);
         rsp_in.rect_width   = to_pix(sel_rect.wid);
         rsp_in.rect_height  = to_pix(sel_rect.hgt);
         rsp_in.is_column    = sel_rect.is_column;
         rsp_in.last_of_item = last_pend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         done_ff       <= '0;
         dstart_ff     <= '0;
         cstart_ff     <= '0;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         done_ff       <= done_in;
         dstart_ff     <= dstart_in;
         cstart_ff     <= cstart_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exec_ff     <= exec_in;
      fwd_a_ff    <= fwd_a_in;
      fwd_b_ff    <= fwd_b_in;
      vld_a_ff    <= vld_a_in;
      vld_b_ff    <= vld_b_in;
      fwd_word_ff <= fwd_word_in;
      rsp_ff      <= rsp_in;
   end

   // Only rectangles that the current tile actually produces are marked sent.
   a_done_subset: assert property (@(posedge clock) disable iff (reset)
      exec_valid_ff |-> ((done_ff & ~rect_en) == '0))
      else $error("sent mask holds a rectangle the tile does not produce");

   // A tile stays in the execute register until all its rectangles are out.
   a_exec_hold: assert property (@(posedge clock) disable iff (reset)
      (exec_valid_ff && !finish) |=> (exec_valid_ff && $stable(exec_ff)))
      else $error("execute register changed before the tile finished");

   // Row rectangles are one tile high, column rectangles one tile wide.
   a_unit_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_ff.is_column ? rsp_ff.rect_width : rsp_ff.rect_height) == PIX_ONE))
      else $error("rectangle short side is not one tile");

endmodule

// ===== rtl/grid_run_rectangle_extractor_core.sv =====
// Grid run rectangle extractor.
//
// Tile occupancy flags enter on req_chan, one item per tile in row-major
// order. Pixel rectangles leave on rsp_chan, zero to three per tile, with
// last_of_item set on the final rectangle that a tile causes. Grid size is
// set through csr_chan (index 0 width, index 1 height); it is always ready
// and must only be written while no tile is in flight.
//
// The first rectangle of a tile passes from the head of the queue, where
// the line-store read is issued, through the execute stage into the output
// register. A tile that yields at most one rectangle leaves the execute
// stage as it is judged, so such streams run at one tile per clock while
// the receiver is ready. A tile that yields several rectangles holds the
// execute stage until the last is sent, as the output register sends one
// rectangle per clock while the receiver is ready.
//
// Reset sets the grid to 64 by 64 tiles, returns the position to the top
// left corner and clears the line-store valid bits. When the receiver
// stalls, the output register holds its rectangle, the execute stage
// waits, and the two-entry queue keeps taking tiles until it fills.
module grid_run_rectangle_extractor_core
   import grec_pkg::*;
#(
   parameter int MAX_WIDTH   = 64,
   parameter int MAX_HEIGHT  = 64,
   parameter int TILE_PIXELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   grec_chan_if.sink   req_chan,
   grec_chan_if.source rsp_chan,
   grec_chan_if.sink   csr_chan
);

   // Classified tiles from the front part, and the queue's output toward the
   // back part.
   grec_chan_if #(.payload_type(item_type)) front_chan ();
   grec_chan_if #(.payload_type(item_type)) back_chan ();

   // The front part tracks the tile position and holds the grid size, so
   // each item carries its column, row and whether it ends a row or lies in
   // the last row.
   grec_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .item_chan (front_chan)
   );

   // The queue lets the front keep accepting tiles while the back part is
   // busy sending several rectangles or waits on the receiver.
   grec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_chan (front_chan),
      .pop_chan  (back_chan)
   );

   // The back part reads the line stores, judges the row above one row
   // late, closes last-row runs and vertical runs, and serializes the
   // resulting rectangles into the output register.
   grec_back #(
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT),
      .TILE_PIXELS (TILE_PIXELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .item_chan (back_chan),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== tb/tb_grid_run_rectangle_extractor_core.sv =====
module tb_grid_run_rectangle_extractor_core;
   timeunit 1ns;
   timeprecision 1ps;

   import grec_pkg::*;

   localparam int MAX_W = 64;
   localparam int MAX_H = 64;
   localparam int TILE = 16;

   // Rough size of the random part of the run, in tiles.
   localparam int RANDOM_TILES = 330;
   // Length of the one long receiver hold-off that backs up the block.
   localparam int LONG_HOLD_CYCLES = 40;
   // Margin after the last expected rectangle, so that a tile that makes no
   // rectangle is surely gone before the next phase.
   localparam int SETTLE_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5ns clock = ~clock;

   grec_chan_if #(.payload_type(req_type)) req_if ();
   grec_chan_if #(.payload_type(rsp_type)) rsp_if ();
   grec_chan_if #(.payload_type(csr_type)) csr_if ();

   grid_run_rectangle_extractor_core #(
      .MAX_WIDTH   (MAX_W),
      .MAX_HEIGHT  (MAX_H),
      .TILE_PIXELS (TILE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // Tiles waiting to be offered, and rectangles waiting to come out.
   bit      tile_queue[$];
   rsp_type rect_expect_q[$];
   rsp_type rect_want;
   int      errors = 0;

   // Handshake pacing. idle_on enables the random bursts on both sides.
   bit idle_on = 1'b0;
   bit req_fire = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   bit hold_req = 1'b0;
   int hold_left = 0;

   // Our own copy of the grid registers and of the block's state.
   bit [CFG_W-1:0] grid_cols_cfg = GRID_WIDTH_RESET;
   bit [CFG_W-1:0] grid_rows_cfg = GRID_HEIGHT_RESET;
   bit             above_row     [MAX_W];
   bit             two_above_row [MAX_W];
   bit [POS_W-1:0] col_run_top   [MAX_W];
   bit [POS_W-1:0] above_run_left = '0;
   bit [POS_W-1:0] this_run_left  = '0;
   bit [POS_W-1:0] next_col = '0;
   bit [POS_W-1:0] next_row = '0;

   function automatic rsp_type make_rect(int left, int top, int wd, int ht, bit col);
      rsp_type r;
      r.rect_left    = PIX_W'(left * TILE);
      r.rect_top     = PIX_W'(top * TILE);
      r.rect_width   = PIX_W'(wd * TILE);
      r.rect_height  = PIX_W'(ht * TILE);
      r.is_column    = col;
      r.last_of_item = 1'b0;
      return r;
   endfunction

   // Works out the rectangles one tile causes and queues them in order:
   // late row run of the row above, row run of the last row, column run.
   function automatic void predict_tile(bit solid);
      int      w, h, x, y, s, len, n, i;
      bit      up, up2, lc, lr;
      rsp_type rects[3];
      w = (grid_cols_cfg == 0) ? 1 : (grid_cols_cfg > MAX_W) ? MAX_W : grid_cols_cfg;
      h = (grid_rows_cfg == 0) ? 1 : (grid_rows_cfg > MAX_H) ? MAX_H : grid_rows_cfg;
      x = (next_col >= MAX_W) ? MAX_W - 1 : next_col;
      y = (next_row >= MAX_H) ? MAX_H - 1 : next_row;
      up = above_row[x];
      up2 = two_above_row[x];
      lc = (x + 1 >= w);
      lr = (y + 1 >= h);
      n = 0;

      if (x == 0) begin
         above_run_left = '0;
         this_run_left = '0;
      end

      // The row above is closed one row late, once the tile below is known.
      if (y >= 1) begin
         if (!up) begin
            above_run_left = POS_W'(x + 1);
         end else if (lc || !above_row[x + 1]) begin
            s = (above_run_left > x) ? x : above_run_left;
            len = x - s + 1;
            if (len >= 2 || y == 1 || (!up2 && !solid)) begin
               rects[n] = make_rect(s, y - 1, len, 1, 1'b0);
               n++;
            end
         end
      end

      // The last row has nothing below it, so its runs close right away.
      if (!solid) begin
         if (lr && this_run_left < x) begin
            rects[n] = make_rect(this_run_left, y, x - this_run_left, 1, 1'b0);
            n++;
         end
         this_run_left = POS_W'(x + 1);
      end else if (lr && lc) begin
         s = (this_run_left > x) ? x : this_run_left;
         rects[n] = make_rect(s, y, x - s + 1, 1, 1'b0);
         n++;
      end

      if (!solid) begin
         if (y >= 1 && up) begin
            s = (col_run_top[x] > y - 1) ? y - 1 : col_run_top[x];
            len = y - s;
            if (len >= 2) begin
               rects[n] = make_rect(x, s, 1, len, 1'b1);
               n++;
            end
         end
      end else begin
         if (y == 0 || !up) col_run_top[x] = POS_W'(y);
         if (lr) begin
            s = (col_run_top[x] > y) ? y : col_run_top[x];
            len = y - s + 1;
            if (len >= 2) begin
               rects[n] = make_rect(x, s, 1, len, 1'b1);
               n++;
            end
         end
      end

      for (i = 0; i < n; i++) begin
         rects[i].last_of_item = (i == n - 1);
         rect_expect_q.push_back(rects[i]);
      end

      two_above_row[x] = up;
      above_row[x] = solid;
      if (lc) begin
         next_col = '0;
         next_row = lr ? '0 : POS_W'(y + 1);
      end else begin
         next_col = POS_W'(x + 1);
         next_row = POS_W'(y);
      end
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endfunction

   // A tile is taken at a rising edge with valid and ready high; the
   // prediction is made right there, and the driver learns of it through
   // req_fire at the next falling edge.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         predict_tile(req_if.payload.tile_solid);
         req_fire = 1'b1;
      end else begin
         req_fire = 1'b0;
      end
   end

   // Tile driver. It holds an offered tile until it is taken, and otherwise
   // either inserts an idle burst or offers the next tile from the queue.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_fire) begin
         // Still waiting for the block to take the current tile.
      end else if (gap_left > 0) begin
         gap_left--;
         req_if.valid <= 1'b0;
      end else if (tile_queue.size() == 0) begin
         req_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         gap_left = $urandom_range(1, 4) - 1;
         req_if.valid <= 1'b0;
      end else begin
         req_if.valid <= 1'b1;
         req_if.payload <= req_type'(tile_queue.pop_front());
      end
   end

   // Receiver readiness. A requested long hold-off takes precedence over
   // the short random stall bursts.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Rectangle checker: every rectangle taken is matched against the
   // oldest one still expected, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rect_expect_q.size() == 0) begin
            $display("%0t: rectangle with none expected, actual left %0d top %0d w %0d h %0d",
                     $time, rsp_if.payload.rect_left, rsp_if.payload.rect_top,
                     rsp_if.payload.rect_width, rsp_if.payload.rect_height);
            errors++;
         end else begin
            rect_want = rect_expect_q.pop_front();
            check_field("rect_left", rect_want.rect_left, rsp_if.payload.rect_left);
            check_field("rect_top", rect_want.rect_top, rsp_if.payload.rect_top);
            check_field("rect_width", rect_want.rect_width, rsp_if.payload.rect_width);
            check_field("rect_height", rect_want.rect_height, rsp_if.payload.rect_height);
            check_field("is_column", rect_want.is_column, rsp_if.payload.is_column);
            check_field("last_of_item", rect_want.last_of_item,
                        rsp_if.payload.last_of_item);
         end
      end
   end

   // Grid registers may only change while nothing is in flight; callers
   // make sure of that through wait_idle first.
   task automatic write_grid_reg(csr_index_type idx, int value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.payload <= '{index: idx, data: CFG_W'(value)};
      do @(posedge clock); while (!csr_if.ready);
      if (idx == CSR_GRID_WIDTH) grid_cols_cfg = CFG_W'(value);
      else grid_rows_cfg = CFG_W'(value);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Waits until every queued tile is taken and every expected rectangle
   // has arrived, then lets tiles that make no rectangle drain as well.
   task automatic wait_idle(int extra);
      while (tile_queue.size() != 0 || req_if.valid || rect_expect_q.size() != 0)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic queue_tiles(int count, int solid_pct);
      repeat (count) tile_queue.push_back($urandom_range(0, 99) < solid_pct);
   endtask

   // A grid dimension for one phase: mostly small grids so that whole frames
   // pass quickly, with the out-of-range values and both ends mixed in.
   function automatic int pick_dim();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 1;
         2:       return 64;
         3:       return $urandom_range(65, 127);
         4:       return $urandom_range(13, 63);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   initial begin
      int sent;
      int phase;
      int count;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frame on a 4 by 3 grid. It has a two-tile run and a lone
      // tile in the top row, a lone tile in a middle row with an empty tile
      // above it, vertical runs closed by the bottom edge, and bottom-row runs
      // closed by an empty tile and by the row end.
      write_grid_reg(CSR_GRID_WIDTH, 4);
      write_grid_reg(CSR_GRID_HEIGHT, 3);
      tile_queue = '{1, 0, 1, 1,
                     0, 1, 0, 1,
                     1, 1, 0, 1};
      wait_idle(SETTLE_CYCLES);

      // Zero registers act as a 1 by 1 grid: every tile is the whole frame.
      write_grid_reg(CSR_GRID_WIDTH, 0);
      write_grid_reg(CSR_GRID_HEIGHT, 0);
      tile_queue = '{1, 0, 1};
      wait_idle(SETTLE_CYCLES);

      // A height above the maximum acts as the maximum; a two-tile vertical
      // run and a wide run in the row above are closed late.
      write_grid_reg(CSR_GRID_WIDTH, 2);
      write_grid_reg(CSR_GRID_HEIGHT, 127);
      tile_queue = '{1, 1, 1, 0, 0, 1};
      wait_idle(SETTLE_CYCLES);

      // Shrinking the height mid-frame puts the current row past the new
      // last row, so it is taken as the last one and wraps from there.
      write_grid_reg(CSR_GRID_HEIGHT, 2);
      tile_queue = '{1, 1, 1, 0};
      wait_idle(SETTLE_CYCLES);

      // Random phases. Each phase picks fresh grid sizes, which lands the
      // changes at arbitrary points of a frame, and its own tile density.
      sent = 0;
      phase = 0;
      while (sent < RANDOM_TILES) begin
         write_grid_reg(CSR_GRID_WIDTH, pick_dim());
         write_grid_reg(CSR_GRID_HEIGHT, pick_dim());
         count = $urandom_range(15, 45);
         // The first two phases run without idling; the final stretch of the
         // run has none either.
         idle_on = (phase >= 2) && (sent < RANDOM_TILES * 4 / 5) &&
                   ($urandom_range(0, 3) != 0);
         queue_tiles(count, $urandom_range(20, 90));
         // Once, the receiver stops for a long while as tiles keep coming,
         // so the block's queue fills and it has to stall its input.
         if (phase == 1) hold_req = 1'b1;
         sent += count;
         phase++;
         wait_idle(SETTLE_CYCLES);
      end

      idle_on = 1'b0;
      wait_idle(SETTLE_CYCLES);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== grid_run_rectangle_extractor_core.f =====
rtl/grec_pkg.sv
rtl/grec_chan_if.sv
rtl/grec_ram.sv
rtl/grec_front.sv
rtl/grec_queue.sv
rtl/grec_back.sv
rtl/grid_run_rectangle_extractor_core.sv
tb/tb_grid_run_rectangle_extractor_core.sv
